// ----- rtl/fdc_pkg.sv -----
// Shared types, constants and the microcode program of the keypad calculator core.
package fdc_pkg;

    localparam int FDC_DIGITS = 4;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 4;
    localparam logic [3:0] MAX_DIGIT = 4'd9;

    // key actions
    localparam logic [1:0] ACT_DIGIT = 2'd0;
    localparam logic [1:0] ACT_OPER  = 2'd1;
    localparam logic [1:0] ACT_APPLY = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // microcode step addresses
    localparam logic [STEP_W-1:0] S_DIGIT     = 4'd0;
    localparam logic [STEP_W-1:0] S_DIG_RCP   = 4'd1;
    localparam logic [STEP_W-1:0] S_DIG_REM   = 4'd2;
    localparam logic [STEP_W-1:0] S_DIG_DONE  = 4'd3;
    localparam logic [STEP_W-1:0] S_OPER      = 4'd4;
    localparam logic [STEP_W-1:0] S_CLEAR     = 4'd5;
    localparam logic [STEP_W-1:0] S_APPLY     = 4'd6;
    localparam logic [STEP_W-1:0] S_CHK_FAULT = 4'd7;
    localparam logic [STEP_W-1:0] S_QDIV      = 4'd8;
    localparam logic [STEP_W-1:0] S_QWAIT     = 4'd9;
    localparam logic [STEP_W-1:0] S_QUOT      = 4'd10;
    localparam logic [STEP_W-1:0] S_CHK_NEG   = 4'd11;
    localparam logic [STEP_W-1:0] S_MOD       = 4'd12;
    localparam logic [STEP_W-1:0] S_TAKE_REM  = 4'd13;
    localparam logic [STEP_W-1:0] S_COMMIT    = 4'd14;

    typedef enum logic [3:0] {
        U_NOP,
        U_X10,      // work = entry * 10
        U_RCP,      // product = work * reciprocal of the modulus
        U_WAIT,     // hold until the divider is done
        U_DIGIT,    // entry = work + digit
        U_OPNEXT,   // step operator
        U_CLEAR,    // zero entry and accumulator, operator back to add
        U_ARITH,    // work = acc op entry (|acc| for divide)
        U_DIV_ENT,  // start divide of work by the entry
        U_QUOT,     // work = signed quotient
        U_REM,      // work = work - quotient estimate * modulus
        U_COMMIT    // accumulator = work unless faulted, entry cleared
    } uop_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_NOTDIV,
        C_FAULT,
        C_NEG
    } cond_t;

    typedef struct packed {
        uop_t              op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              fin;
    } ucode_t;

    typedef struct packed {
        uop_t op;
        logic fire;
        logic fin;
    } ctrl_t;

    typedef struct packed {
        logic not_div;
        logic fault;
        logic w_neg;
        logic div_busy;
    } stat_t;

    typedef struct packed {
        logic [DATA_W-1:0] shown;
        logic [1:0]        op_index;
        logic              name;
        logic              fault;
    } res_t;

    function automatic logic [STEP_W-1:0] fdc_entry_pt(input logic [1:0] action);
        logic [STEP_W-1:0] s;
        begin
            unique case (action)
                ACT_DIGIT: s = S_DIGIT;
                ACT_OPER:  s = S_OPER;
                ACT_APPLY: s = S_APPLY;
                default:   s = S_CLEAR;
            endcase
            return s;
        end
    endfunction

    function automatic ucode_t fdc_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        begin
            w = '{op: U_NOP, cond: C_NONE, target: S_DIGIT, fin: 1'b0};
            unique case (step)
                S_DIGIT:     w.op = U_X10;
                S_DIG_RCP:   w.op = U_RCP;
                S_DIG_REM:   w.op = U_REM;
                S_DIG_DONE:  begin w.op = U_DIGIT;  w.fin = 1'b1; end
                S_OPER:      begin w.op = U_OPNEXT; w.fin = 1'b1; end
                S_CLEAR:     begin w.op = U_CLEAR;  w.fin = 1'b1; end
                S_APPLY:     begin
                    w.op = U_ARITH; w.cond = C_NOTDIV; w.target = S_CHK_NEG;
                end
                S_CHK_FAULT: begin w.cond = C_FAULT; w.target = S_COMMIT; end
                S_QDIV:      w.op = U_DIV_ENT;
                S_QWAIT:     w.op = U_WAIT;
                S_QUOT:      w.op = U_QUOT;
                S_CHK_NEG:   begin w.cond = C_NEG; w.target = S_COMMIT; end
                S_MOD:       w.op = U_RCP;
                S_TAKE_REM:  w.op = U_REM;
                default:     begin w.op = U_COMMIT; w.fin = 1'b1; end
            endcase
            return w;
        end
    endfunction

endpackage

// ----- rtl/fdc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module fdc_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [fdc_pkg::DATA_W-1:0] dividend,
    input  logic [fdc_pkg::DATA_W-1:0] divisor,
    output logic                      busy,
    output logic [fdc_pkg::DATA_W-1:0] quot
);
    localparam int W     = fdc_pkg::DATA_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     q_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     d_reg;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    assign shifted = {r_reg, q_reg[W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                r_reg <= diff[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end else begin
                r_reg <= shifted[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

// ----- rtl/fdc_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
module fdc_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [1:0]           action,
    input  fdc_pkg::stat_t       stat,
    input  logic                 out_free,
    output fdc_pkg::ctrl_t       ctrl,
    output logic                 busy
);
    logic                        busy_reg;
    logic [fdc_pkg::STEP_W-1:0]  step_reg;
    fdc_pkg::ucode_t             word;
    logic                        fire;
    logic                        cond_true;

    assign word = fdc_pkg::fdc_rom(step_reg);

    // final steps hold until the output register can take the result; the wait step holds while the divider is busy
    assign fire = busy_reg && (!word.fin || out_free)
                  && !(word.op == fdc_pkg::U_WAIT && stat.div_busy);

    always_comb begin
        unique case (word.cond)
            fdc_pkg::C_NOTDIV: cond_true = stat.not_div;
            fdc_pkg::C_FAULT:  cond_true = stat.fault;
            fdc_pkg::C_NEG:    cond_true = stat.w_neg;
            default:           cond_true = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= fdc_pkg::fdc_entry_pt(action);
        end else if (fire) begin
            if (word.fin) begin
                busy_reg <= 1'b0;
            end else if (cond_true) begin
                step_reg <= word.target;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.fire = fire;
    assign ctrl.fin  = word.fin;
    assign busy      = busy_reg;
endmodule

// ----- rtl/fdc_dpath.sv -----
// Calculator datapath: entry, accumulator, operator, work register and divider.
module fdc_dpath #(
    parameter int DIGITS = fdc_pkg::FDC_DIGITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [3:0]     digit_in,
    input  fdc_pkg::ctrl_t ctrl,
    output fdc_pkg::stat_t stat,
    output fdc_pkg::res_t  res
);
    localparam int W       = fdc_pkg::DATA_W;
    localparam int MODV    = 10 ** DIGITS;
    localparam int ENTRY_W = $clog2(MODV);
    localparam logic [W-1:0] MOD = W'(MODV);
    localparam int PROD_W  = 2 * W;
    // floor(w * RECIP / 2**SHIFT) is the exact quotient by the modulus for any w below 2**31
    localparam int SHIFT   = (W - 1) + ENTRY_W;
    localparam logic [PROD_W-1:0] RECIP_FULL =
        ((PROD_W'(1) << SHIFT) + PROD_W'(MODV) - PROD_W'(1)) / PROD_W'(MODV);
    localparam logic [W-1:0] RECIP = W'(RECIP_FULL);

    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [W-1:0]       acc_reg, acc_next;
    logic [1:0]         opsel_reg, opsel_next;
    logic               fault_reg, fault_next;
    logic [W-1:0]       w_reg, w_next;
    logic               neg_reg, neg_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [W-1:0]       quot_est;
    logic [3:0]         digit_reg;
    logic [3:0]         digit_sat;
    logic [W-1:0]       entry_x;
    logic               div_start;
    logic               div_busy;
    logic [W-1:0]       div_quot;
    logic               go;

    assign entry_x   = {{(W-ENTRY_W){1'b0}}, entry_reg};
    assign digit_sat = (digit_reg > fdc_pkg::MAX_DIGIT) ? fdc_pkg::MAX_DIGIT : digit_reg;
    assign go        = ctrl.fire;
    assign quot_est  = W'(prod_reg >> SHIFT);

    assign div_start = go && (ctrl.op == fdc_pkg::U_DIV_ENT);

    fdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (w_reg),
        .divisor  (entry_x),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_comb begin
        entry_next = entry_reg;
        acc_next   = acc_reg;
        opsel_next = opsel_reg;
        fault_next = fault_reg;
        w_next     = w_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        res        = '0;
        if (start) begin
            fault_next = 1'b0;
        end
        if (go) begin
            unique case (ctrl.op)
                fdc_pkg::U_X10: begin
                    w_next = (entry_x << 3) + (entry_x << 1);
                end
                fdc_pkg::U_RCP: begin
                    // work is never negative here
                    prod_next = PROD_W'(w_reg[W-2:0]) * PROD_W'(RECIP);
                end
                fdc_pkg::U_DIGIT: begin
                    entry_next = ENTRY_W'(w_reg) + ENTRY_W'(digit_sat);
                end
                fdc_pkg::U_OPNEXT: begin
                    opsel_next = opsel_reg + 2'd1;
                end
                fdc_pkg::U_CLEAR: begin
                    entry_next = '0;
                    acc_next   = '0;
                    opsel_next = fdc_pkg::OP_ADD;
                end
                fdc_pkg::U_ARITH: begin
                    neg_next = acc_reg[W-1];
                    case (opsel_reg)
                        fdc_pkg::OP_ADD: w_next = acc_reg + entry_x;
                        fdc_pkg::OP_MUL: w_next = acc_reg * entry_x;
                        fdc_pkg::OP_SUB: w_next = acc_reg - entry_x;
                        default: begin
                            w_next     = acc_reg[W-1] ? (~acc_reg + 1'b1) : acc_reg;
                            fault_next = (entry_reg == '0);
                        end
                    endcase
                end
                fdc_pkg::U_QUOT: begin
                    w_next = neg_reg ? (~div_quot + 1'b1) : div_quot;
                end
                fdc_pkg::U_REM: begin
                    w_next = w_reg - quot_est * MOD;
                end
                fdc_pkg::U_COMMIT: begin
                    if (!fault_reg) begin
                        acc_next = w_reg;
                    end
                    entry_next = '0;
                end
                default: ;
            endcase
        end
        // result of the final step, taken into the output register
        res.op_index = opsel_next;
        res.fault    = fault_reg;
        case (ctrl.op)
            fdc_pkg::U_DIGIT:  res.shown = {{(W-ENTRY_W){1'b0}}, entry_next};
            fdc_pkg::U_OPNEXT: res.name  = 1'b1;
            fdc_pkg::U_COMMIT: res.shown = acc_next;
            default: ;
        endcase
        if (ctrl.op != fdc_pkg::U_COMMIT) begin
            res.fault = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            acc_reg   <= '0;
            opsel_reg <= fdc_pkg::OP_ADD;
            fault_reg <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            acc_reg   <= acc_next;
            opsel_reg <= opsel_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg    <= w_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        if (start) begin
            digit_reg <= digit_in;
        end
    end

    assign stat.not_div  = (opsel_reg != fdc_pkg::OP_DIV);
    assign stat.fault    = fault_reg;
    assign stat.w_neg    = w_reg[W-1];
    assign stat.div_busy = div_busy;
endmodule

// ----- rtl/four_digit_calculator_core.sv -----
// A digit key multiplies the entry by ten, reduces it below the modulus and adds the digit;
// an operator or clear key goes straight to its final step. An apply computes, reduces and
// commits, a divide running the serial divider first; a negative result or a divide by zero
// skips the reduction. One request in progress at a time; the next is accepted once its
// result is loaded, and the final step stalls while the output register is still full.
// Synchronous active-low reset zeroes entry, accumulator, operator and control.
module four_digit_calculator_core #(
    parameter int DIGITS = fdc_pkg::FDC_DIGITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] digit
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] shown_value
    output logic [3:0]  m_tuser    // [1:0] op_index, [2] show_op_name, [3] divide_fault
);
    localparam logic [31:0] MOD = 32'(10 ** DIGITS);

    logic           accept;
    logic           out_free;
    logic           seq_busy;
    fdc_pkg::ctrl_t ctrl;
    fdc_pkg::stat_t stat;
    fdc_pkg::res_t  res;
    logic           m_tvalid_reg;
    logic [31:0]    m_tdata_reg;
    logic [3:0]     m_tuser_reg;

    assign s_tready = !seq_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    fdc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .action   (s_tuser),
        .stat     (stat),
        .out_free (out_free),
        .ctrl     (ctrl),
        .busy     (seq_busy)
    );

    fdc_dpath #(
        .DIGITS (DIGITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .digit_in (s_tdata[3:0]),
        .ctrl     (ctrl),
        .stat     (stat),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.fire && ctrl.fin) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fire && ctrl.fin) begin
            m_tdata_reg <= res.shown;
            m_tuser_reg <= {res.fault, res.name, res.op_index};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a new result only comes out of a request that was in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a request in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata == 32'd0)
        else $error("operator name shown with nonzero value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[1:0] == fdc_pkg::OP_DIV)
        else $error("divide fault without divide selected");

    // every non-negative shown value has been reduced below the modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[31] |-> m_tdata < MOD)
        else $error("shown value not reduced");
endmodule

// ----- dv/tb_four_digit_calculator_core.sv -----
// Self-checking testbench for the keypad calculator core: random key streams vs. a local predictor.
module tb_four_digit_calculator_core;

    localparam logic [31:0] DEC_MOD = 32'(10 ** fdc_pkg::FDC_DIGITS);
    localparam int RANDOM_KEYS = 1200;
    localparam int LONG_HOLD = 2000;

    typedef struct {
        logic [1:0] action;
        logic [3:0] digit;
    } key_t;

    typedef struct {
        logic [31:0] shown;
        logic [1:0]  op_index;
        logic        name;
        logic        fault;
    } key_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    key_t        key_queue[$];
    key_result_t expected_results[$];
    key_t        next_key;
    key_result_t want;

    // predictor state
    logic [31:0] calc_entry = '0;
    logic [31:0] calc_acc   = '0;
    logic [1:0]  calc_op    = fdc_pkg::OP_ADD;

    int errors = 0;
    int total_keys = 0;
    int keys_accepted = 0;
    int results_seen = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int seg_left = 0;
    int rx_mode = 0;
    bit long_hold_done = 1'b0;
    int n_apply = 0, n_fault = 0, n_neg = 0, n_sat = 0, n_div = 0;

    four_digit_calculator_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic key_result_t press_key(input logic [1:0] act, input logic [3:0] dig);
        key_result_t r;
        logic [31:0] a, b, v, mag, q;
        logic [3:0]  d;
        r = '{shown: '0, op_index: '0, name: 1'b0, fault: 1'b0};
        case (act)
            fdc_pkg::ACT_DIGIT: begin
                d = dig;
                if (dig > fdc_pkg::MAX_DIGIT) begin
                    d = fdc_pkg::MAX_DIGIT;
                    n_sat++;
                end
                calc_entry = (calc_entry * 10) % DEC_MOD + 32'(d);
                r.shown = calc_entry;
            end
            fdc_pkg::ACT_OPER: begin
                calc_op = calc_op + 2'd1;
                r.name = 1'b1;
            end
            fdc_pkg::ACT_APPLY: begin
                a = calc_acc;
                b = calc_entry;
                v = a;
                n_apply++;
                case (calc_op)
                    fdc_pkg::OP_ADD: v = a + b;
                    fdc_pkg::OP_MUL: v = a * b;
                    fdc_pkg::OP_SUB: v = a - b;
                    default: begin
                        if (b == 0) begin
                            r.fault = 1'b1;
                            n_fault++;
                        end else begin
                            // truncate toward zero on the magnitude
                            mag = a[31] ? -a : a;
                            q = mag / b;
                            v = a[31] ? -q : q;
                            n_div++;
                        end
                    end
                endcase
                if (!r.fault && !v[31])
                    v = v % DEC_MOD;
                if (v[31])
                    n_neg++;
                calc_acc = v;
                calc_entry = '0;
                r.shown = v;
            end
            default: begin
                calc_entry = '0;
                calc_acc = '0;
                calc_op = fdc_pkg::OP_ADD;
            end
        endcase
        r.op_index = calc_op;
        return r;
    endfunction

    task automatic add_key(input logic [1:0] act, input logic [3:0] dig);
        key_t k;
        k.action = act;
        k.digit = dig;
        key_queue.push_back(k);
    endtask

    task automatic check_field(input string what, input logic [31:0] w, input logic [31:0] g);
        if (w !== g) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, w, g);
        end
    endtask

    // sender: bursts of requests separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(press_key(s_tuser, s_tdata[3:0]));
                keys_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (key_queue.size() != 0) begin
                    next_key = key_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, next_key.digit};
                    s_tuser <= next_key.action;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 120)
                                                              : $urandom_range(0, 3);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes per segment, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(10, 200);
                rx_mode <= $urandom_range(0, 3);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 99) < 2);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0h / %0h",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_results.pop_front();
                check_field("shown_value", want.shown, m_tdata);
                check_field("op_index", 32'(want.op_index), 32'(m_tuser[1:0]));
                check_field("show_op_name", 32'(want.name), 32'(m_tuser[2]));
                check_field("divide_fault", 32'(want.fault), 32'(m_tuser[3]));
            end
        end
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int n_dig, n_cyc, i, pick;
        // directed: saturation, entry wrap, each operator, negative, zero divide, wrap of op
        add_key(fdc_pkg::ACT_DIGIT, 4'd0);
        add_key(fdc_pkg::ACT_DIGIT, 4'd15);
        add_key(fdc_pkg::ACT_DIGIT, 4'd10);
        add_key(fdc_pkg::ACT_DIGIT, 4'd9);
        add_key(fdc_pkg::ACT_DIGIT, 4'd9);
        add_key(fdc_pkg::ACT_DIGIT, 4'd9);
        add_key(fdc_pkg::ACT_APPLY, 4'd0);
        add_key(fdc_pkg::ACT_OPER, 4'd5);
        for (i = 0; i < 4; i++)
            add_key(fdc_pkg::ACT_DIGIT, 4'd9);
        add_key(fdc_pkg::ACT_APPLY, 4'd15);
        add_key(fdc_pkg::ACT_OPER, 4'd0);
        add_key(fdc_pkg::ACT_DIGIT, 4'd5);
        add_key(fdc_pkg::ACT_APPLY, 4'd0);
        add_key(fdc_pkg::ACT_OPER, 4'd0);
        add_key(fdc_pkg::ACT_APPLY, 4'd0);
        add_key(fdc_pkg::ACT_DIGIT, 4'd3);
        add_key(fdc_pkg::ACT_APPLY, 4'd0);
        add_key(fdc_pkg::ACT_OPER, 4'd0);
        add_key(fdc_pkg::ACT_DIGIT, 4'd12);
        add_key(fdc_pkg::ACT_CLEAR, 4'd7);
        add_key(fdc_pkg::ACT_APPLY, 4'd0);
        while (key_queue.size() < RANDOM_KEYS + 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                // well-formed: pick operator, key in an operand, apply
                n_cyc = $urandom_range(0, 3);
                for (i = 0; i < n_cyc; i++)
                    add_key(fdc_pkg::ACT_OPER, 4'($urandom_range(0, 15)));
                n_dig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
                for (i = 0; i < n_dig; i++)
                    add_key(fdc_pkg::ACT_DIGIT,
                            ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                                        : 4'($urandom_range(0, 9)));
                add_key(fdc_pkg::ACT_APPLY, 4'($urandom_range(0, 15)));
            end else if (pick < 90) begin
                add_key(fdc_pkg::ACT_CLEAR, 4'($urandom_range(0, 15)));
            end else begin
                add_key(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end
        end
        total_keys = key_queue.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (keys_accepted < total_keys || expected_results.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Covered %0d keys, %0d applies: %0d divides, %0d zero divides, %0d negative",
                 total_keys, n_apply, n_div, n_fault, n_neg);
        $display("results; %0d saturated digits; one long output hold-off of %0d cycles.",
                 n_sat, LONG_HOLD);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fdc_pkg.sv
rtl/fdc_div.sv
rtl/fdc_seq.sv
rtl/fdc_dpath.sv
rtl/four_digit_calculator_core.sv
dv/tb_four_digit_calculator_core.sv
